>>> rtl/fbfla_pkg.sv
package fbfla_pkg;

    // pool size limit and the widths that follow from it
    localparam int MAX_BUFFERS = 1024;
    localparam int SLOT_W      = $clog2(MAX_BUFFERS);
    localparam int LINK_W      = $clog2(MAX_BUFFERS + 1);

    // configuration register widths
    localparam int BLOCK_W  = 32;
    localparam int BUF_W    = 17;
    localparam int OFFSET_W = 16;
    localparam int TAG_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // request and result field widths
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int BOFF_W   = 32;
    localparam int PROD_W   = SLOT_W + BUF_W;

    // stream bus widths, fields packed from bit 0 and padded to bytes
    localparam int S_DATA_BITS = SLOT_W + TAG_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = SLOT_W + BOFF_W + LINK_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    // reset values of the configuration registers
    localparam logic [BLOCK_W-1:0]  BLOCK_SIZE_RST     = BLOCK_W'(65536);
    localparam logic [BUF_W-1:0]    BUFFER_SIZE_RST    = BUF_W'(64);
    localparam logic [OFFSET_W-1:0] INITIAL_OFFSET_RST = '0;
    localparam logic [TAG_W-1:0]    ALLOCATOR_TAG_RST  = '0;

    // divider for the pool size
    localparam int DIV_W     = BLOCK_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK           = 2'd0,
        STS_EXHAUSTED    = 2'd1,
        STS_WRONG_OWNER  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE     = 2'd0,
        CFG_BUFFER_SIZE    = 2'd1,
        CFG_INITIAL_OFFSET = 2'd2,
        CFG_ALLOCATOR_TAG  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FILL,
        S_DONE
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic load_count;
        logic fill_we;
        logic finish;
    } fbfla_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic div_busy;
        logic fill_end;
    } fbfla_sts_t;

endpackage

>>> rtl/fbfla_div.sv
module fbfla_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fbfla_pkg::DIV_W-1:0]    dividend,
    input  logic [fbfla_pkg::BUF_W-1:0]    divisor,
    output logic                           busy,
    output logic [fbfla_pkg::DIV_W-1:0]    quotient
);
    import fbfla_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [BUF_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [BUF_W-1:0]     dvs_reg;

    logic [BUF_W:0] trial;
    logic [BUF_W:0] diff;
    logic           ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[BUF_W-1:0] : trial[BUF_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/fbfla_ctrl.sv
module fbfla_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic [fbfla_pkg::REQ_W-1:0] req_type,
    output logic                        s_tready,
    input  fbfla_pkg::fbfla_sts_t       sts,
    output fbfla_pkg::fbfla_cmd_t       cmd
);
    import fbfla_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (req_type == REQ_INIT) ? S_DIV : S_DONE;
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (sts.fill_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.div_start  = 1'b0;
        cmd.load_count = 1'b0;
        cmd.fill_we    = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.accept    = s_tvalid;
                cmd.div_start = s_tvalid && (req_type == REQ_INIT);
            end
            S_DIV:
            begin
                cmd.load_count = !sts.div_busy;
            end
            S_FILL:
            begin
                cmd.fill_we = !sts.fill_end;
            end
            S_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/fbfla_dpath.sv
module fbfla_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0] cfg_data,
    // request fields
    input  logic [fbfla_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [fbfla_pkg::REQ_W-1:0]      s_tuser,
    // result
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fbfla_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [fbfla_pkg::STATUS_W-1:0]   m_tuser,
    // control
    input  fbfla_pkg::fbfla_cmd_t            cmd,
    output fbfla_pkg::fbfla_sts_t            sts
);
    import fbfla_pkg::*;

    // configuration registers
    logic [BLOCK_W-1:0]  block_size_reg;
    logic [BUF_W-1:0]    buffer_size_reg;
    logic [OFFSET_W-1:0] initial_offset_reg;
    logic [TAG_W-1:0]    allocator_tag_reg;

    // free list state
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] head_next;
    logic [LINK_W-1:0] slot_count_reg;
    logic [LINK_W-1:0] link_mem [MAX_BUFFERS];
    logic [LINK_W-1:0] rd_data_reg;

    // latched request
    logic [REQ_W-1:0]  req_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [PROD_W-1:0] prod_reg;

    // initialise sweep
    logic [LINK_W-1:0] count_reg;
    logic [LINK_W-1:0] count_next;
    logic [LINK_W-1:0] fill_idx_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [BOFF_W-1:0]   offset_reg;
    logic [LINK_W-1:0]   bcount_reg;
    logic [STATUS_W-1:0] status_next;
    logic [SLOT_W-1:0]   out_slot_next;
    logic [BOFF_W-1:0]   offset_next;
    logic [LINK_W-1:0]   bcount_next;

    // divider
    logic [DIV_W-1:0] room;
    logic [DIV_W-1:0] quotient;
    logic             div_busy;
    logic             no_room;

    // decode
    logic              alloc_ok;
    logic              tag_ok;
    logic              free_in_pool;
    logic              free_push;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    logic [LINK_W-1:0] mem_wd;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg     <= BLOCK_SIZE_RST;
            buffer_size_reg    <= BUFFER_SIZE_RST;
            initial_offset_reg <= INITIAL_OFFSET_RST;
            allocator_tag_reg  <= ALLOCATOR_TAG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:     block_size_reg     <= cfg_data[BLOCK_W-1:0];
                CFG_BUFFER_SIZE:    buffer_size_reg    <= cfg_data[BUF_W-1:0];
                CFG_INITIAL_OFFSET: initial_offset_reg <= cfg_data[OFFSET_W-1:0];
                CFG_ALLOCATOR_TAG:  allocator_tag_reg  <= cfg_data[TAG_W-1:0];
                default:            block_size_reg     <= block_size_reg;
            endcase
        end
    end

    // latch request fields, start the offset multiply on accept
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= s_tuser;
            slot_reg <= s_tdata[SLOT_W-1:0];
            tag_reg  <= s_tdata[SLOT_W +: TAG_W];
            prod_reg <= head_reg[SLOT_W-1:0] * buffer_size_reg;
        end
    end

    // pool size: room / buffer_size, capped, or zero when there is no room
    assign room    = block_size_reg - DIV_W'(initial_offset_reg);
    assign no_room = (buffer_size_reg == '0)
                  || (BLOCK_W'(initial_offset_reg) > block_size_reg);

    fbfla_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (room),
        .divisor  (buffer_size_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        if (no_room)
        begin
            count_next = '0;
        end
        else if (quotient > DIV_W'(MAX_BUFFERS))
        begin
            count_next = LINK_W'(MAX_BUFFERS);
        end
        else
        begin
            count_next = quotient[LINK_W-1:0];
        end
    end

    // pool size and sweep index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            fill_idx_reg <= '0;
        end
        else if (cmd.load_count)
        begin
            count_reg    <= count_next;
            fill_idx_reg <= '0;
        end
        else if (cmd.fill_we)
        begin
            fill_idx_reg <= fill_idx_reg + 1'b1;
        end
    end

    // request decode
    assign alloc_ok     = (head_reg < slot_count_reg);
    assign tag_ok       = (tag_reg == allocator_tag_reg);
    assign free_in_pool = ({1'b0, slot_reg} < slot_count_reg);
    assign free_push    = cmd.finish && (req_reg == REQ_FREE) && tag_ok && free_in_pool;

    // link memory write port: sweep or push
    assign mem_we = cmd.fill_we || free_push;
    assign mem_wa = cmd.fill_we ? fill_idx_reg[SLOT_W-1:0] : slot_reg;
    assign mem_wd = cmd.fill_we ? (fill_idx_reg + 1'b1) : head_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_wa] <= mem_wd;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= link_mem[head_reg[SLOT_W-1:0]];
        end
    end

    // result and head update
    always_comb
    begin
        status_next   = STS_OK;
        out_slot_next = '0;
        offset_next   = '0;
        bcount_next   = '0;
        head_next     = head_reg;
        case (req_reg)
            REQ_ALLOC:
            begin
                if (alloc_ok)
                begin
                    out_slot_next = head_reg[SLOT_W-1:0];
                    offset_next   = BOFF_W'(initial_offset_reg) + BOFF_W'(prod_reg);
                    head_next     = rd_data_reg;
                end
                else
                begin
                    status_next = STS_EXHAUSTED;
                end
            end
            REQ_FREE:
            begin
                if (!tag_ok)
                begin
                    status_next = STS_WRONG_OWNER;
                end
                else if (free_in_pool)
                begin
                    head_next = {1'b0, slot_reg};
                end
            end
            REQ_INIT:
            begin
                bcount_next = count_reg;
                head_next   = '0;
            end
            default:
            begin
                status_next = STS_OK;
            end
        endcase
    end

    // free list head and size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            slot_count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            head_reg <= head_next;
            if (req_reg == REQ_INIT)
            begin
                slot_count_reg <= count_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg   <= status_next;
            out_slot_reg <= out_slot_next;
            offset_reg   <= offset_next;
            bcount_reg   <= bcount_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_DATA_W'({bcount_reg, offset_reg, out_slot_reg});

    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.div_busy = div_busy;
    assign sts.fill_end = (fill_idx_reg == count_reg);

    // head never points past the end-of-list mark
    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= slot_count_reg)
        else $error("free list head beyond pool size");

    // pool size never exceeds the slot store
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        slot_count_reg <= LINK_W'(MAX_BUFFERS))
        else $error("pool size above capacity");

    // a result is only loaded when the output register can take it
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before delivery");

    // sweep writes stay inside the new pool
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_we |-> (fill_idx_reg < count_reg))
        else $error("sweep write beyond pool size");

    // after a push the head is the freed slot
    a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
        free_push |=> (head_reg == {1'b0, $past(slot_reg)}))
        else $error("freed slot not at head");

endmodule

>>> rtl/fixed_block_free_list_allocator_unit.sv
// Fixed-size buffer pool allocator over a linked free list of slot indices.
// Requests enter on the s_ stream (kind in s_tuser: allocate, free, initialise),
// results leave on the m_ stream, one result per request, in request order.
// Configuration (region size, buffer size, first offset, owner tag) is written
// through cfg_we / cfg_index / cfg_data while no request is outstanding.
// Allocate, free and unused codes are accepted while the link memory is read at
// the head and the offset multiply runs; then, once the output register is free,
// the head is updated and the result register loaded. A result is visible on
// m_tvalid after that load; the next request is accepted from then on.
// Initialise runs a bit-serial divider for the pool size, then one link-memory
// write per slot (N slots), then the result.
// Reset clears the head and pool size, so allocate reports exhaustion until the
// first initialise; configuration returns to its reset values. The link memory
// is not cleared and needs no clearing pass.
// When the receiver stalls, the finished result waits in the output register
// and the block still accepts one more request, holding its result back until
// the output register is taken.
module fixed_block_free_list_allocator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fbfla_pkg::S_DATA_W-1:0]   s_tdata,  // slot_index, owner_tag
    input  logic [fbfla_pkg::REQ_W-1:0]      s_tuser,  // req_type
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fbfla_pkg::M_DATA_W-1:0]   m_tdata,  // out_slot, buffer_offset, buffer_count
    output logic [fbfla_pkg::STATUS_W-1:0]   m_tuser   // status
);
    import fbfla_pkg::*;

    fbfla_cmd_t cmd;
    fbfla_sts_t sts;

    // sequencing
    fbfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // free list, configuration and result register
    fbfla_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> verif/fixed_block_free_list_allocator_unit_tb.sv
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_unit_tb;

    import fbfla_pkg::*;

    // request code with no meaning to the block
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 92;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 50;
    localparam int HOLD_CYCLES    = 300;

    // one result as it leaves the block
    typedef struct packed {
        status_t                  status;
        logic [SLOT_W-1:0]        slot;
        logic [BOFF_W-1:0]        offset;
        logic [LINK_W-1:0]        count;
    } alloc_result_t;

    // one row of the directed table: a register write or a request
    typedef struct {
        bit                       is_cfg;
        cfg_idx_t                 idx;
        logic [CFG_DATA_W-1:0]    val;
        logic [REQ_W-1:0]         kind;
        logic [SLOT_W-1:0]        slot;
        logic [TAG_W-1:0]         tag;
        bit                       typed;
        alloc_result_t            want;
    } table_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    // predictor copy of the configuration
    logic [BLOCK_W-1:0]     cfg_block;
    logic [BUF_W-1:0]       cfg_buf;
    logic [OFFSET_W-1:0]    cfg_offset;
    logic [TAG_W-1:0]       cfg_tag;

    // predictor copy of the free list
    logic [LINK_W-1:0]      link_mem [MAX_BUFFERS];
    logic [LINK_W-1:0]      pool_head;
    logic [LINK_W-1:0]      pool_count;

    alloc_result_t          pending_results [$];
    int                     held_slots [$];
    table_row_t             directed_rows [$];

    int                     mismatch_count;
    int                     cycle_count;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     hold_left;
    bit                     hold_req;

    fixed_block_free_list_allocator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // expected result of one request, updating the free list copy
    function automatic alloc_result_t predict_pool(input logic [REQ_W-1:0] kind,
                                                   input logic [SLOT_W-1:0] slot,
                                                   input logic [TAG_W-1:0] tag);
        alloc_result_t r;
        logic [31:0]   room;
        logic [31:0]   n;
        r = '0;
        case (kind)
            REQ_ALLOC:
            begin
                if (pool_head < pool_count)
                begin
                    r.slot   = pool_head[SLOT_W-1:0];
                    r.offset = 32'(cfg_offset) + 32'(pool_head) * 32'(cfg_buf);
                    pool_head = link_mem[pool_head[SLOT_W-1:0]];
                end
                else
                begin
                    r.status = STS_EXHAUSTED;
                end
            end
            REQ_FREE:
            begin
                if (tag != cfg_tag)
                begin
                    r.status = STS_WRONG_OWNER;
                end
                else if (LINK_W'(slot) < pool_count)
                begin
                    link_mem[slot] = pool_head;
                    pool_head = LINK_W'(slot);
                end
            end
            REQ_INIT:
            begin
                n = '0;
                if (cfg_buf != '0 && 32'(cfg_offset) <= cfg_block)
                begin
                    room = cfg_block - 32'(cfg_offset);
                    n = room / 32'(cfg_buf);
                    if (n > MAX_BUFFERS)
                    begin
                        n = MAX_BUFFERS;
                    end
                end
                for (int i = 0; i < n; i++)
                begin
                    link_mem[i] = LINK_W'(i + 1);
                end
                pool_head  = '0;
                pool_count = n[LINK_W-1:0];
                r.count    = n[LINK_W-1:0];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic alloc_result_t res(input status_t st, input int slot,
                                          input logic [31:0] offset, input int count);
        alloc_result_t r;
        r.status = st;
        r.slot   = SLOT_W'(slot);
        r.offset = offset;
        r.count  = LINK_W'(count);
        return r;
    endfunction

    function automatic table_row_t req_row(input logic [REQ_W-1:0] kind, input int slot,
                                           input int tag, input bit typed,
                                           input alloc_result_t want);
        table_row_t row;
        row.is_cfg = 1'b0;
        row.idx    = CFG_BLOCK_SIZE;
        row.val    = '0;
        row.kind   = kind;
        row.slot   = SLOT_W'(slot);
        row.tag    = TAG_W'(tag);
        row.typed  = typed;
        row.want   = want;
        return row;
    endfunction

    function automatic table_row_t cfg_row(input cfg_idx_t idx, input logic [31:0] val);
        table_row_t row;
        row = req_row(REQ_ALLOC, 0, 0, 1'b0, '0);
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        return row;
    endfunction

    // register write, only once every result is back
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            CFG_BLOCK_SIZE:     cfg_block  = val;
            CFG_BUFFER_SIZE:    cfg_buf    = val[BUF_W-1:0];
            CFG_INITIAL_OFFSET: cfg_offset = val[OFFSET_W-1:0];
            CFG_ALLOCATOR_TAG:  cfg_tag    = val[TAG_W-1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // offer one request and book its expected result once accepted
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                                input logic [TAG_W-1:0] tag, input bit typed,
                                input alloc_result_t want);
        alloc_result_t predicted;
        int            found;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = S_DATA_W'({tag, slot});
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predicted = predict_pool(kind, slot, tag);
        pending_results.push_back(typed ? want : predicted);
        // track slots that are out on loan so frees can be well formed
        if (kind == REQ_INIT)
        begin
            held_slots.delete();
        end
        else if (kind == REQ_ALLOC && predicted.status == STS_OK)
        begin
            held_slots.push_back(int'(predicted.slot));
        end
        else if (kind == REQ_FREE && predicted.status == STS_OK)
        begin
            found = -1;
            for (int k = 0; k < held_slots.size(); k++)
            begin
                if (found < 0 && held_slots[k] == int'(slot))
                begin
                    found = k;
                end
            end
            if (found >= 0)
            begin
                held_slots.delete(found);
            end
        end
        @(negedge clk);
    endtask

    // receiver readiness, with a long hold-off on demand
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = status_t'(m_tuser);
            got.slot   = m_tdata[SLOT_W-1:0];
            got.offset = m_tdata[SLOT_W +: BOFF_W];
            got.count  = m_tdata[SLOT_W+BOFF_W +: LINK_W];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual 0x%0h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("out_slot", 32'(want.slot), 32'(got.slot));
                check_field("buffer_offset", want.offset, got.offset);
                check_field("buffer_count", 32'(want.count), 32'(got.count));
            end
        end
    end

    // main sequence
    initial
    begin
        logic [REQ_W-1:0]  kind;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic [31:0]       bsize;
        logic [31:0]       boff;
        logic [31:0]       bblock;
        int                roll;
        int                n;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BLOCK_SIZE;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_ALLOC;
        m_tready       = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_left      = 0;
        hold_req       = 1'b0;
        send_idle_pct  = 36;
        recv_idle_pct  = 79;

        // predictor state after reset
        cfg_block  = BLOCK_SIZE_RST;
        cfg_buf    = BUFFER_SIZE_RST;
        cfg_offset = INITIAL_OFFSET_RST;
        cfg_tag    = ALLOCATOR_TAG_RST;
        pool_head  = '0;
        pool_count = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // nothing built yet, then the full pool from the reset values
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_EXHAUSTED, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_FREE, 5, 0, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_UNUSED, 1023, 255, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_INIT, 0, 0, 1, res(STS_OK, 0, 0, 1024)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 1, 64, 0)));
        // wrong owner, then a double free handing the slot out twice
        directed_rows.push_back(req_row(REQ_FREE, 1, 255, 1, res(STS_WRONG_OWNER, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_FREE, 1, 0, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_FREE, 1, 0, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 1, 64, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 1, 64, 0)));
        directed_rows.push_back(req_row(REQ_FREE, 1023, 0, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 1023, 65472, 0)));
        // registers changed after the pool was built
        directed_rows.push_back(cfg_row(CFG_INITIAL_OFFSET, 32'h0000_FFFF));
        directed_rows.push_back(cfg_row(CFG_BUFFER_SIZE, 32'h0001_FFFF));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 0, '0));
        // first buffer beyond the region
        directed_rows.push_back(cfg_row(CFG_BLOCK_SIZE, 32'h0000_0100));
        directed_rows.push_back(req_row(REQ_INIT, 0, 0, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_EXHAUSTED, 0, 0, 0)));
        // zero buffer size over the largest region
        directed_rows.push_back(cfg_row(CFG_BLOCK_SIZE, 32'hFFFF_FFFF));
        directed_rows.push_back(cfg_row(CFG_BUFFER_SIZE, 32'h0000_0000));
        directed_rows.push_back(req_row(REQ_INIT, 0, 0, 1, res(STS_OK, 0, 0, 0)));
        // three buffers with a spare tail, drained and refilled
        directed_rows.push_back(cfg_row(CFG_BUFFER_SIZE, 32'h40));
        directed_rows.push_back(cfg_row(CFG_INITIAL_OFFSET, 32'h20));
        directed_rows.push_back(cfg_row(CFG_ALLOCATOR_TAG, 32'hA5));
        directed_rows.push_back(cfg_row(CFG_BLOCK_SIZE, 32'h20 + 3 * 32'h40 + 32'h3F));
        directed_rows.push_back(req_row(REQ_INIT, 0, 0, 1, res(STS_OK, 0, 0, 3)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 0, 32'h20, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 1, 32'h60, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 2, 32'hA0, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_EXHAUSTED, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_FREE, 2, 'hA5, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_FREE, 3, 'hA5, 1, res(STS_OK, 0, 0, 0)));
        directed_rows.push_back(req_row(REQ_ALLOC, 0, 0, 1, res(STS_OK, 2, 32'hA0, 0)));

        // directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
            begin
                write_reg(directed_rows[r].idx, directed_rows[r].val);
            end
            else
            begin
                send_request(directed_rows[r].kind, directed_rows[r].slot,
                             directed_rows[r].tag, directed_rows[r].typed,
                             directed_rows[r].want);
            end
        end

        // random phases, each with its own pool
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES / 3)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 36;
            end
            else if (p == 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p == 0)
            begin
                // largest pool with the smallest buffers
                bsize  = 32'd64;
                boff   = 32'd0;
                bblock = 32'hFFFF_FFFF;
            end
            else if (p == 5)
            begin
                // widest buffer and offset, pool capped
                bsize  = 32'h0001_FFFF;
                boff   = 32'h0000_FFFF;
                bblock = 32'hFFFF_FFFF;
            end
            else
            begin
                if ($urandom_range(3) == 0)
                begin
                    bsize = $urandom_range(1, 32'h1FFFF);
                end
                else
                begin
                    bsize = 64 * $urandom_range(1, 1024);
                end
                boff   = $urandom_range(0, 16'hFFFF);
                n      = $urandom_range(1, 48);
                bblock = boff + bsize * n + $urandom_range(0, bsize - 1);
            end
            write_reg(CFG_BLOCK_SIZE, bblock);
            write_reg(CFG_BUFFER_SIZE, bsize);
            write_reg(CFG_INITIAL_OFFSET, boff);
            write_reg(CFG_ALLOCATOR_TAG, (p == 0) ? 32'hFF : 32'($urandom_range(0, 255)));

            // receiver stalls long enough for the block to back up
            if (p == 2 * RANDOM_PHASES / 3)
            begin
                hold_req = 1'b1;
            end

            send_request(REQ_INIT, SLOT_W'($urandom), TAG_W'($urandom), 1'b0, '0);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                roll = $urandom_range(99);
                kind = REQ_ALLOC;
                slot = SLOT_W'($urandom);
                tag  = cfg_tag;
                if (roll < 42)
                begin
                    kind = REQ_ALLOC;
                end
                else if (roll < 80)
                begin
                    // well-formed free of a slot on loan
                    if (held_slots.size() != 0)
                    begin
                        kind = REQ_FREE;
                        slot = SLOT_W'(held_slots[$urandom_range(0, held_slots.size() - 1)]);
                    end
                end
                else if (roll < 87)
                begin
                    // any slot: outside the pool or a double free
                    kind = REQ_FREE;
                end
                else if (roll < 92)
                begin
                    kind = REQ_FREE;
                    tag  = TAG_W'($urandom);
                    if (tag == cfg_tag)
                    begin
                        tag = ~tag;
                    end
                end
                else if (roll < 95)
                begin
                    kind = REQ_UNUSED;
                    tag  = TAG_W'($urandom);
                end
                else if (roll < 97)
                begin
                    kind = REQ_INIT;
                    tag  = TAG_W'($urandom);
                end
                send_request(kind, slot, tag, 1'b0, '0);
            end
        end

        // drain and finish
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
